// File: sv/sha256_stream_hash_macros.svh
// Assertion macros shared by the SHA-256 stream hash checker.
// No dependencies.
`ifndef SHA256_STREAM_HASH_MACROS_SVH
`define SHA256_STREAM_HASH_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: sv/sha_pkg.sv
// Package for the SHA-256 stream hash: round constants, initial hash values,
// queue entry type, state type and a rotate-right helper. No dependencies.
package sha_pkg;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
		logic       no_byte;
	} item_t;

	typedef enum logic [2:0] {
		B_IDLE, B_ROUND, B_ADD, B_PAD, B_OUT
	} bstate_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		ror = (x >> n) | (x << (32 - n));
	endfunction
endpackage

// File: sv/sha_front.sv
// Front part of the SHA-256 stream hash: accepts input transfers, drops
// byteless items that do not end a message, and queues the rest. Uses sha_pkg.
module sha_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sha_pkg::item_t    in_item,
	output logic              q_valid,
	input  logic              q_ready,
	output sha_pkg::item_t    q_item
);
	sha_pkg::item_t            mem_q [sha_pkg::QDEPTH];
	logic [sha_pkg::QAW-1:0]   wp_q, rp_q;
	logic [sha_pkg::QAW:0]     cnt_q;
	logic                      push, pop;

	assign in_ready = (cnt_q != 3'(sha_pkg::QDEPTH));
	// Byteless items without the end flag change nothing and are dropped here.
	assign push = in_valid && in_ready && !(in_item.no_byte && !in_item.is_last);
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule

// File: sv/sha_back.sv
// Back part of the SHA-256 stream hash: block buffer, message schedule,
// one-round-per-cycle compression, padding and digest output. Uses sha_pkg.
module sha_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  sha_pkg::item_t    q_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);
	sha_pkg::bstate_t state_q, state_d;
	logic [31:0] w_q [16];      // sliding schedule window, big-endian words
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic        fin_q;         // the message has been closed, padding is owed
	logic        pad_q;         // the 0x80 pad byte has been written
	logic        lenblk_q;      // current compressed block holds the length
	logic [2:0]  oidx_q;

	logic [31:0] wt, s0, s1, wnew, t1, t2, e, a;
	logic        take, byte_in;
	logic [1:0]  bsel;
	logic [3:0]  widx;
	logic [7:0]  wbyte;
	logic        do_write;

	assign wt = w_q[0];
	assign s0 = sha_pkg::ror(w_q[1], 7) ^ sha_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = sha_pkg::ror(w_q[14], 17) ^ sha_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wnew = w_q[0] + s0 + w_q[9] + s1;
	assign e = v_q[4];
	assign a = v_q[0];
	assign t1 = v_q[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
		+ ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::ROUND_K[rnd_q] + wt;
	assign t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
		+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign q_ready = (state_q == sha_pkg::B_IDLE);
	assign take = q_valid && q_ready;
	assign byte_in = take && !q_item.no_byte;

	// Byte written into the buffer this cycle: message byte, pad byte or
	// length byte, or a zero byte for the fill between them.
	// The length goes only into the block where position 56 follows the pad.
	always_comb begin
		do_write = 1'b0;
		wbyte = '0;
		if (byte_in) begin
			do_write = 1'b1; wbyte = q_item.data_byte;
		end else if (state_q == sha_pkg::B_PAD) begin
			do_write = 1'b1;
			if (!pad_q) wbyte = sha_pkg::PAD_BYTE;
			else if (fill_q >= 6'd56 && (lenblk_q || fill_q == 6'd56))
				wbyte = len_q[8*(63 - fill_q) +: 8];
			else wbyte = 8'h00;
		end
	end
	assign widx = fill_q[5:2];
	assign bsel = fill_q[1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			sha_pkg::B_IDLE: begin
				if (take && q_item.is_last) state_d = sha_pkg::B_PAD;
				if (byte_in && fill_q == 6'd63) state_d = sha_pkg::B_ROUND;
			end
			sha_pkg::B_PAD:
				if (fill_q == 6'd63) state_d = sha_pkg::B_ROUND;
			sha_pkg::B_ROUND:
				if (rnd_q == 6'd63) state_d = sha_pkg::B_ADD;
			sha_pkg::B_ADD: begin
				if (lenblk_q) state_d = sha_pkg::B_OUT;
				else if (fin_q) state_d = sha_pkg::B_PAD;
				else state_d = sha_pkg::B_IDLE;
			end
			sha_pkg::B_OUT:
				if (out_ready && oidx_q == 3'd7) state_d = sha_pkg::B_IDLE;
			default: state_d = sha_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		out_valid = (state_q == sha_pkg::B_OUT);
		digest_word = h_q[oidx_q];
		word_index = oidx_q;
		last_word = (oidx_q == 3'd7);
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			if (bsel == 2'd0) w_q[widx] <= {wbyte, 24'h0};
			else w_q[widx][8*(3 - bsel) +: 8] <= wbyte;
		end
		if (state_q == sha_pkg::B_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else if (state_d == sha_pkg::B_ROUND) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::B_IDLE;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_HASH[i];
			fill_q <= '0; len_q <= '0; rnd_q <= '0;
			fin_q <= 1'b0; pad_q <= 1'b0; lenblk_q <= 1'b0; oidx_q <= '0;
		end else begin
			state_q <= state_d;
			if (byte_in) len_q <= len_q + 64'd8;
			if (do_write) fill_q <= fill_q + 1'b1;
			// Pad byte goes in the first padding cycle; later cycles hold zeros
			// and, once the position reaches 56 with room, the length.
			if (take && q_item.is_last) fin_q <= 1'b1;
			if (state_q == sha_pkg::B_PAD && !pad_q) pad_q <= 1'b1;
			if (state_q == sha_pkg::B_PAD && pad_q && fill_q == 6'd56) lenblk_q <= 1'b1;
			if (state_q == sha_pkg::B_ROUND) rnd_q <= rnd_q + 1'b1;
			if (state_q == sha_pkg::B_ADD) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				rnd_q <= '0;
			end
			if (state_q == sha_pkg::B_OUT && out_ready) begin
				oidx_q <= oidx_q + 1'b1;
				if (oidx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_HASH[i];
					len_q <= '0; fill_q <= '0; fin_q <= 1'b0; pad_q <= 1'b0;
					lenblk_q <= 1'b0;
				end
			end
		end
	end
endmodule

// File: sv/sha256_stream_hash.sv
// Top level of the SHA-256 stream hash: front queue plus compression back end.
// Depends on sha_pkg, sha_front and sha_back.
//
// Usage: message bytes arrive on the s_axis channel, one per transfer.
// s_axis_tlast marks the final transfer; with s_axis_tuser set that transfer
// carries no byte (this also hashes the empty message). A byteless transfer
// without tlast is accepted and discarded.
// The digest leaves on m_axis as eight transfers, word 0 (most significant)
// first; m_axis_tuser carries the word index and m_axis_tlast the eighth word.
// Throughput: one byte a cycle into a four-entry queue while it has room; the
// back end absorbs a byte per cycle while idle and takes no bytes while it
// compresses a full 64-byte block on the single round unit (64 rounds and a
// final add). Closing a message costs padding and one or two compressions
// after the final transfer leaves the queue, before the first digest word
// appears.
// A stalled receiver holds the current digest word; the queue keeps taking
// bytes until full. Reset clears the queue, the chaining words to the initial
// hash values and the length and fill counts; no clearing pass is needed.
module sha256_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,
	input  logic        s_axis_tuser,   // [0] no_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic        m_axis_tlast,
	output logic [2:0]  m_axis_tuser    // [2:0] word_index
);
	sha_pkg::item_t in_item, q_item;
	logic           q_valid, q_ready;

	assign in_item.data_byte = s_axis_tdata;
	assign in_item.is_last = s_axis_tlast;
	assign in_item.no_byte = s_axis_tuser;

	sha_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item,
		.q_valid, .q_ready, .q_item);

	sha_back u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_item,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.digest_word(m_axis_tdata), .word_index(m_axis_tuser),
		.last_word(m_axis_tlast));
endmodule

// File: sv/sha_checker.sv
// Port-level checker for the SHA-256 stream hash, bound to the top level.
// Depends on sha256_stream_hash_macros.svh.
`include "sha256_stream_hash_macros.svh"
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [2:0]  m_axis_tuser
);
	`SHA_ASSERT_IMP(a_last_idx, clk, arst_n, m_axis_tvalid,
		(m_axis_tlast == (m_axis_tuser == 3'd7)), "tlast must mark word seven")
	`SHA_ASSERT_NEXT(a_idx_step, clk, arst_n,
		m_axis_tvalid && m_axis_tready && !m_axis_tlast,
		m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1,
		"digest words must follow without gaps")
	`SHA_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled digest word must hold")
endmodule

bind sha256_stream_hash sha_checker u_checker (.*);
